// ===== design/quaternion_arith_unit_defines.svh =====
// Assertion macros for the quaternion arithmetic unit.
`ifndef QUATERNION_ARITH_UNIT_DEFINES_SVH
`define QUATERNION_ARITH_UNIT_DEFINES_SVH

// Checked on every clock edge outside reset.
`define QAU_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define QAU_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/qau_pkg.sv =====
package qau_pkg;

  typedef enum logic [1:0] {
    CMD_MUL  = 2'd0,
    CMD_ROT  = 2'd1,
    CMD_CONJ = 2'd2,
    CMD_NORM = 2'd3
  } cmd_t;

  typedef struct packed {
    logic signed [31:0] w;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } quat_t;

  typedef struct packed {
    quat_t q;
    logic  zero_norm;
    logic  clipped;
  } res_t;

  typedef struct packed {
    logic               clip;
    logic signed [31:0] val;
  } sat_t;

  localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

  // Square root: 66-bit radicand, one root bit per stage.
  localparam int SQ_W   = 66;
  localparam int ROOT_W = 33;
  localparam int REM_W  = ROOT_W + 2;

  localparam int MUL_LAT  = 6;
  localparam int DIV_LAT  = 32;
  localparam int NORM_LAT = 3 + ROOT_W + 1 + DIV_LAT + 1;
  localparam int MUL_DLY  = NORM_LAT - MUL_LAT;

  function automatic sat_t sat64(input logic signed [63:0] v);
    sat_t r;
    if (v > 64'sh0000_0000_7FFF_FFFF) begin
      r.clip = 1'b1;
      r.val  = Q_MAX;
    end else if (v < 64'shFFFF_FFFF_8000_0000) begin
      r.clip = 1'b1;
      r.val  = Q_MIN;
    end else begin
      r.clip = 1'b0;
      r.val  = v[31:0];
    end
    return r;
  endfunction

  function automatic sat_t neg_sat(input logic signed [31:0] v);
    sat_t r;
    if (v == Q_MIN) begin
      r.clip = 1'b1;
      r.val  = Q_MAX;
    end else begin
      r.clip = 1'b0;
      r.val  = -v;
    end
    return r;
  endfunction

endpackage

// ===== design/qau_hamilton.sv =====
module qau_hamilton #(
  parameter int FRAC_BITS = 28
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           adv,
  input  logic           in_vld,
  input  logic [1:0]     in_cmd,
  input  qau_pkg::quat_t a,
  input  qau_pkg::quat_t b,
  output logic           out_vld,
  output logic [1:0]     out_cmd,
  output qau_pkg::res_t  res
);
  import qau_pkg::*;

  localparam logic signed [63:0] HALF = 64'sd1 <<< (FRAC_BITS - 1);

  logic [MUL_LAT-1:0] vld;
  logic [1:0]         cmd_q [MUL_LAT];

  logic signed [31:0] av [4];
  logic signed [31:0] bv [4];
  sat_t               cjx, cjy, cjz;

  // stage 0: a*b products
  logic signed [63:0] p0 [4][4];
  quat_t              a0, cj0;
  logic               cc0;
  // stage 1: rounded
  logic signed [63:0] r1 [4][4];
  quat_t              a1, cj1;
  logic               cc1;
  // stage 2: first quaternion (product or a*v)
  quat_t              t2, a2, cj2;
  logic               k2, cc2;
  sat_t               sw, sx, sy, sz;
  logic signed [31:0] tv [4];
  // stage 3: t*a products
  logic signed [63:0] u3 [4][4];
  quat_t              t3, cj3;
  logic               k3, cc3;
  // stage 4: rounded
  logic signed [63:0] r4 [4][4];
  quat_t              t4, cj4;
  logic               k4, cc4;
  // stage 5: result
  sat_t               ox, oy, oz;
  res_t               res_next;

  always_comb begin
    av[0] = a.w;
    av[1] = a.x;
    av[2] = a.y;
    av[3] = a.z;
    // a*v treats the vector as a quaternion with zero scalar
    bv[0] = (cmd_t'(in_cmd) == CMD_ROT) ? 32'sd0 : b.w;
    bv[1] = b.x;
    bv[2] = b.y;
    bv[3] = b.z;
    cjx   = neg_sat(a.x);
    cjy   = neg_sat(a.y);
    cjz   = neg_sat(a.z);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[MUL_LAT-2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cmd_q[0] <= in_cmd;
      for (int i = 1; i < MUL_LAT; i++) begin
        cmd_q[i] <= cmd_q[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 4; i++) begin
        for (int j = 0; j < 4; j++) begin
          p0[i][j] <= av[i] * bv[j];
        end
      end
      a0  <= a;
      cj0 <= {a.w, cjx.val, cjy.val, cjz.val};
      cc0 <= cjx.clip | cjy.clip | cjz.clip;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 4; i++) begin
        for (int j = 0; j < 4; j++) begin
          r1[i][j] <= (p0[i][j] + HALF) >>> FRAC_BITS;
        end
      end
      a1  <= a0;
      cj1 <= cj0;
      cc1 <= cc0;
    end
  end

  always_comb begin
    sw = sat64(r1[0][0] - r1[1][1] - r1[2][2] - r1[3][3]);
    sx = sat64(r1[0][1] + r1[1][0] + r1[2][3] - r1[3][2]);
    sy = sat64(r1[0][2] + r1[2][0] + r1[3][1] - r1[1][3]);
    sz = sat64(r1[0][3] + r1[3][0] + r1[1][2] - r1[2][1]);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      t2  <= {sw.val, sx.val, sy.val, sz.val};
      k2  <= sw.clip | sx.clip | sy.clip | sz.clip;
      a2  <= a1;
      cj2 <= cj1;
      cc2 <= cc1;
    end
  end

  always_comb begin
    tv[0] = t2.w;
    tv[1] = t2.x;
    tv[2] = t2.y;
    tv[3] = t2.z;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 4; k++) begin
        u3[k][0] <= tv[k] * a2.w;
        u3[k][1] <= tv[k] * a2.x;
        u3[k][2] <= tv[k] * a2.y;
        u3[k][3] <= tv[k] * a2.z;
      end
      t3  <= t2;
      k3  <= k2;
      cj3 <= cj2;
      cc3 <= cc2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 4; i++) begin
        for (int j = 0; j < 4; j++) begin
          r4[i][j] <= (u3[i][j] + HALF) >>> FRAC_BITS;
        end
      end
      t4  <= t3;
      k4  <= k3;
      cj4 <= cj3;
      cc4 <= cc3;
    end
  end

  // t*conj(a), negating after rounding
  always_comb begin
    ox = sat64(-r4[0][1] + r4[1][0] - r4[2][3] + r4[3][2]);
    oy = sat64(-r4[0][2] + r4[2][0] - r4[3][1] + r4[1][3]);
    oz = sat64(-r4[0][3] + r4[3][0] - r4[1][2] + r4[2][1]);
    res_next = '0;
    case (cmd_t'(cmd_q[4]))
      CMD_MUL: begin
        res_next.q       = t4;
        res_next.clipped = k4;
      end
      CMD_ROT: begin
        res_next.q       = {32'sd0, ox.val, oy.val, oz.val};
        res_next.clipped = k4 | ox.clip | oy.clip | oz.clip;
      end
      CMD_CONJ: begin
        res_next.q       = cj4;
        res_next.clipped = cc4;
      end
      default: begin
        res_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res <= res_next;
    end
  end

  assign out_vld = vld[MUL_LAT-1];
  assign out_cmd = cmd_q[MUL_LAT-1];

endmodule

// ===== design/qau_isqrt.sv =====
module qau_isqrt #(
  parameter int PAY_W = 128
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       adv,
  input  logic                       in_vld,
  input  logic [qau_pkg::SQ_W-1:0]   rad,
  input  logic [PAY_W-1:0]           in_pay,
  output logic                       out_vld,
  output logic [qau_pkg::ROOT_W-1:0] root,
  output logic [PAY_W-1:0]           out_pay
);
  import qau_pkg::*;

  logic              st_vld  [ROOT_W];
  logic [SQ_W-1:0]   st_rad  [ROOT_W];
  logic [REM_W-1:0]  st_rem  [ROOT_W];
  logic [ROOT_W-1:0] st_root [ROOT_W];
  logic [PAY_W-1:0]  st_pay  [ROOT_W];

  for (genvar g = 0; g < ROOT_W; g++) begin : g_st
    logic              vld_in;
    logic [SQ_W-1:0]   rad_in;
    logic [REM_W-1:0]  rem_in;
    logic [ROOT_W-1:0] root_in;
    logic [PAY_W-1:0]  pay_in;
    logic [REM_W+1:0]  cand;
    logic [REM_W+1:0]  trial;
    logic [REM_W+1:0]  diff;
    logic              take;

    if (g == 0) begin : g_first
      assign vld_in  = in_vld;
      assign rad_in  = rad;
      assign rem_in  = '0;
      assign root_in = '0;
      assign pay_in  = in_pay;
    end else begin : g_next
      assign vld_in  = st_vld[g-1];
      assign rad_in  = st_rad[g-1];
      assign rem_in  = st_rem[g-1];
      assign root_in = st_root[g-1];
      assign pay_in  = st_pay[g-1];
    end

    // bring down the next two radicand bits, try root*4+1
    assign cand  = {rem_in, rad_in[SQ_W-1-2*g -: 2]};
    assign trial = {2'b00, root_in, 2'b01};
    assign diff  = cand - trial;
    assign take  = (cand >= trial);

    always_ff @(posedge clk) begin
      if (rst) begin
        st_vld[g] <= 1'b0;
      end else if (adv) begin
        st_vld[g] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        st_rad[g]  <= rad_in;
        st_pay[g]  <= pay_in;
        st_rem[g]  <= take ? diff[REM_W-1:0] : cand[REM_W-1:0];
        st_root[g] <= {root_in[ROOT_W-2:0], take};
      end
    end
  end

  assign out_vld = st_vld[ROOT_W-1];
  assign root    = st_root[ROOT_W-1];
  assign out_pay = st_pay[ROOT_W-1];

endmodule

// ===== design/qau_norm.sv =====
module qau_norm #(
  parameter int FRAC_BITS = 28
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           adv,
  input  logic           in_vld,
  input  qau_pkg::quat_t a,
  output logic           out_vld,
  output qau_pkg::res_t  res
);
  import qau_pkg::*;

  logic signed [31:0] ain [4];
  logic [2:0]         vld;
  logic [63:0]        sq1 [4];
  quat_t              a1, a2, a3;
  logic [64:0]        s01, s23;
  logic [65:0]        s3;

  logic              sq_vld;
  logic [ROOT_W-1:0] sq_root;
  quat_t             sq_a;

  logic signed [31:0] lv [4];
  logic [31:0]        absv [4];
  logic [63:0]        lim;

  logic              dvld [DIV_LAT+1];
  logic [31:0]       dq   [DIV_LAT+1][4];
  logic [3:0]        dneg [DIV_LAT+1];
  logic [3:0]        dovf [DIV_LAT+1];
  logic              dzn  [DIV_LAT+1];
  logic [63:0]       dr   [DIV_LAT][4];
  logic [ROOT_W-1:0] dn   [DIV_LAT];

  logic signed [31:0] ov [4];
  logic [3:0]         oclip;
  res_t               res_next;

  always_comb begin
    ain[0] = a.w;
    ain[1] = a.x;
    ain[2] = a.y;
    ain[3] = a.z;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[1:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 4; i++) begin
        sq1[i] <= $unsigned(64'(ain[i]) * 64'(ain[i]));
      end
      a1  <= a;
      s01 <= {1'b0, sq1[0]} + {1'b0, sq1[1]};
      s23 <= {1'b0, sq1[2]} + {1'b0, sq1[3]};
      a2  <= a1;
      s3  <= {1'b0, s01} + {1'b0, s23};
      a3  <= a2;
    end
  end

  qau_isqrt #(
    .PAY_W ($bits(quat_t))
  ) u_isqrt (
    .clk     (clk),
    .rst     (rst),
    .adv     (adv),
    .in_vld  (vld[2]),
    .rad     (s3),
    .in_pay  (a3),
    .out_vld (sq_vld),
    .root    (sq_root),
    .out_pay (sq_a)
  );

  // divider setup: magnitudes, and quotient overflow where |a| >= n * 2^(32-F)
  always_comb begin
    lv[0] = sq_a.w;
    lv[1] = sq_a.x;
    lv[2] = sq_a.y;
    lv[3] = sq_a.z;
    lim   = {{(64-ROOT_W){1'b0}}, sq_root} << (32 - FRAC_BITS);
    for (int i = 0; i < 4; i++) begin
      absv[i] = lv[i][31] ? (~lv[i] + 32'd1) : lv[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dvld[0] <= 1'b0;
    end else if (adv) begin
      dvld[0] <= sq_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 4; i++) begin
        dq[0][i]   <= '0;
        dr[0][i]   <= {32'b0, absv[i]} << FRAC_BITS;
        dneg[0][i] <= lv[i][31];
        dovf[0][i] <= ({32'b0, absv[i]} >= lim);
      end
      dn[0]  <= sq_root;
      dzn[0] <= (sq_root == '0);
    end
  end

  for (genvar j = 1; j <= DIV_LAT; j++) begin : g_div
    localparam int B = DIV_LAT - j;
    logic [63:0] sub;
    logic [3:0]  take;
    logic [63:0] diff [4];

    assign sub = {{(64-ROOT_W){1'b0}}, dn[j-1]} << B;

    always_comb begin
      for (int i = 0; i < 4; i++) begin
        take[i] = (dr[j-1][i] >= sub);
        diff[i] = dr[j-1][i] - sub;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dvld[j] <= 1'b0;
      end else if (adv) begin
        dvld[j] <= dvld[j-1];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        for (int i = 0; i < 4; i++) begin
          dq[j][i] <= dq[j-1][i] | ({31'b0, take[i]} << B);
        end
        dneg[j] <= dneg[j-1];
        dovf[j] <= dovf[j-1];
        dzn[j]  <= dzn[j-1];
      end
    end

    if (j < DIV_LAT) begin : g_rem
      always_ff @(posedge clk) begin
        if (adv) begin
          for (int i = 0; i < 4; i++) begin
            dr[j][i] <= take[i] ? diff[i] : dr[j-1][i];
          end
          dn[j] <= dn[j-1];
        end
      end
    end
  end

  // apply sign and clamp to the Q range; a zero norm gives zero
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      ov[i]    = '0;
      oclip[i] = 1'b0;
      if (dzn[DIV_LAT]) begin
        ov[i] = '0;
      end else if (!dneg[DIV_LAT][i]) begin
        if (dovf[DIV_LAT][i] || dq[DIV_LAT][i][31]) begin
          ov[i]    = Q_MAX;
          oclip[i] = 1'b1;
        end else begin
          ov[i] = dq[DIV_LAT][i];
        end
      end else begin
        if (dovf[DIV_LAT][i] || (dq[DIV_LAT][i] > 32'h8000_0000)) begin
          ov[i]    = Q_MIN;
          oclip[i] = 1'b1;
        end else begin
          ov[i] = ~dq[DIV_LAT][i] + 32'd1;
        end
      end
    end
    res_next.q         = {ov[0], ov[1], ov[2], ov[3]};
    res_next.zero_norm = dzn[DIV_LAT];
    res_next.clipped   = |oclip;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (adv) begin
      out_vld <= dvld[DIV_LAT];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res <= res_next;
    end
  end

endmodule

// ===== design/quaternion_arith_unit.sv =====
// Channel  Handshake              Payload
// in       in_valid / in_stall    cmd, a_w a_x a_y a_z, b_w b_x b_y b_z
// out      out_valid / out_stall  r_w r_x r_y r_z, zero_norm, clipped
//
// One transaction enters per cycle while in_stall is low.
// The normalize path is the longest: 33 square root stages and a
// 32-stage divider, one bit per stage; the other opcodes are delayed to match.
// Reset clears the valid bits only.
// A valid result held by out_stall freezes every stage at once and is passed
// back as in_stall.
`include "quaternion_arith_unit_defines.svh"

module quaternion_arith_unit #(
  parameter int FRAC_BITS = 28
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         cmd,
  input  logic signed [31:0] a_w,
  input  logic signed [31:0] a_x,
  input  logic signed [31:0] a_y,
  input  logic signed [31:0] a_z,
  input  logic signed [31:0] b_w,
  input  logic signed [31:0] b_x,
  input  logic signed [31:0] b_y,
  input  logic signed [31:0] b_z,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] r_w,
  output logic signed [31:0] r_x,
  output logic signed [31:0] r_y,
  output logic signed [31:0] r_z,
  output logic               zero_norm,
  output logic               clipped
);
  import qau_pkg::*;

  logic       adv;
  quat_t      a_in, b_in;
  logic       hm_vld;
  logic [1:0] hm_cmd;
  res_t       hm_res;
  logic       nm_vld;
  res_t       nm_res;

  logic       dl_vld [MUL_DLY];
  logic [1:0] dl_cmd [MUL_DLY];
  res_t       dl_res [MUL_DLY];
  res_t       out_res;

  // hold every stage while the output waits
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;
  assign a_in     = {a_w, a_x, a_y, a_z};
  assign b_in     = {b_w, b_x, b_y, b_z};

  qau_hamilton #(
    .FRAC_BITS (FRAC_BITS)
  ) u_hamilton (
    .clk     (clk),
    .rst     (rst),
    .adv     (adv),
    .in_vld  (in_valid),
    .in_cmd  (cmd),
    .a       (a_in),
    .b       (b_in),
    .out_vld (hm_vld),
    .out_cmd (hm_cmd),
    .res     (hm_res)
  );

  qau_norm #(
    .FRAC_BITS (FRAC_BITS)
  ) u_norm (
    .clk     (clk),
    .rst     (rst),
    .adv     (adv),
    .in_vld  (in_valid),
    .a       (a_in),
    .out_vld (nm_vld),
    .res     (nm_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MUL_DLY; i++) begin
        dl_vld[i] <= 1'b0;
      end
    end else if (adv) begin
      dl_vld[0] <= hm_vld;
      for (int i = 1; i < MUL_DLY; i++) begin
        dl_vld[i] <= dl_vld[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dl_cmd[0] <= hm_cmd;
      dl_res[0] <= hm_res;
      for (int i = 1; i < MUL_DLY; i++) begin
        dl_cmd[i] <= dl_cmd[i-1];
        dl_res[i] <= dl_res[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= nm_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_res <= (cmd_t'(dl_cmd[MUL_DLY-1]) == CMD_NORM) ? nm_res : dl_res[MUL_DLY-1];
    end
  end

  assign r_w       = out_res.q.w;
  assign r_x       = out_res.q.x;
  assign r_y       = out_res.q.y;
  assign r_z       = out_res.q.z;
  assign zero_norm = out_res.zero_norm;
  assign clipped   = out_res.clipped;

  `QAU_ASSERT(a_path_align, nm_vld == dl_vld[MUL_DLY-1], "product and normalize paths out of step")
  `QAU_ASSERT(a_zero_norm_out, out_valid && zero_norm |-> (r_w == 0) && (r_x == 0) && (r_y == 0) && (r_z == 0) && !clipped, "zero norm with nonzero result")
  `QAU_ASSERT_ALWAYS(a_rst_clear, $past(rst) |-> !out_valid, "output valid after reset")

endmodule

// ===== tb/quaternion_arith_unit_checker.sv =====
`timescale 1ns / 1ps

module quaternion_arith_unit_checker
  import qau_pkg::*;
#(
  parameter int FRAC_BITS = 28
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [1:0]         cmd,
  input  logic signed [31:0] a_w,
  input  logic signed [31:0] a_x,
  input  logic signed [31:0] a_y,
  input  logic signed [31:0] a_z,
  input  logic signed [31:0] b_w,
  input  logic signed [31:0] b_x,
  input  logic signed [31:0] b_y,
  input  logic signed [31:0] b_z,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic signed [31:0] r_w,
  input  logic signed [31:0] r_x,
  input  logic signed [31:0] r_y,
  input  logic signed [31:0] r_z,
  input  logic               zero_norm,
  input  logic               clipped,
  output int                 fail_count,
  output int                 pending,
  output int                 matched
);

  typedef struct packed {
    logic [31:0] w;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic        zn;
    logic        clp;
  } quat_result_t;

  quat_result_t expected_q[$];

  initial begin
    fail_count = 0;
    matched = 0;
  end

  assign pending = expected_q.size();

  // Round a full product back to FRAC_BITS fraction bits, halves up.
  function automatic longint fx_mul(input longint p, input longint q);
    longint prod;
    prod = p * q + (64'sd1 <<< (FRAC_BITS - 1));
    return prod >>> FRAC_BITS;
  endfunction

  function automatic longint clamp32(input longint v, inout bit clp);
    if (v > 64'sd2147483647) begin
      clp = 1'b1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      clp = 1'b1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  function automatic logic [63:0] root_floor(input logic [63:0] v);
    logic [63:0] res;
    logic [63:0] bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic quat_result_t predict_quat(
    input cmd_t op,
    input longint aw, input longint ax, input longint ay, input longint az,
    input longint bw, input longint bx, input longint by, input longint bz);
    quat_result_t res;
    longint rw, rx, ry, rz, tw, tx, ty, tz, d;
    logic [63:0] sq, s, t, n;
    bit clp, zn, carry;
    rw = 0; rx = 0; ry = 0; rz = 0;
    clp = 0; zn = 0; carry = 0;
    case (op)
      CMD_MUL: begin
        rw = clamp32(fx_mul(aw, bw) - fx_mul(ax, bx) - fx_mul(ay, by) - fx_mul(az, bz), clp);
        rx = clamp32(fx_mul(aw, bx) + fx_mul(ax, bw) + fx_mul(ay, bz) - fx_mul(az, by), clp);
        ry = clamp32(fx_mul(aw, by) + fx_mul(ay, bw) + fx_mul(az, bx) - fx_mul(ax, bz), clp);
        rz = clamp32(fx_mul(aw, bz) + fx_mul(az, bw) + fx_mul(ax, by) - fx_mul(ay, bx), clp);
      end
      CMD_ROT: begin
        tw = clamp32(-fx_mul(ax, bx) - fx_mul(ay, by) - fx_mul(az, bz), clp);
        tx = clamp32(fx_mul(aw, bx) + fx_mul(ay, bz) - fx_mul(az, by), clp);
        ty = clamp32(fx_mul(aw, by) + fx_mul(az, bx) - fx_mul(ax, bz), clp);
        tz = clamp32(fx_mul(aw, bz) + fx_mul(ax, by) - fx_mul(ay, bx), clp);
        rx = clamp32(-fx_mul(tw, ax) + fx_mul(tx, aw) - fx_mul(ty, az) + fx_mul(tz, ay), clp);
        ry = clamp32(-fx_mul(tw, ay) + fx_mul(ty, aw) - fx_mul(tz, ax) + fx_mul(tx, az), clp);
        rz = clamp32(-fx_mul(tw, az) + fx_mul(tz, aw) - fx_mul(tx, ay) + fx_mul(ty, ax), clp);
      end
      CMD_CONJ: begin
        rw = aw;
        rx = clamp32(-ax, clp);
        ry = clamp32(-ay, clp);
        rz = clamp32(-az, clp);
      end
      default: begin
        s = 0;
        for (int i = 0; i < 4; i++) begin
          case (i)
            0: sq = aw * aw;
            1: sq = ax * ax;
            2: sq = ay * ay;
            default: sq = az * az;
          endcase
          t = s + sq;
          if (t < s) carry = 1;
          s = t;
        end
        // Four squares of -2^31 wrap to exactly 2^64.
        n = carry ? (64'd1 << 32) : root_floor(s);
        if (n == 0) begin
          zn = 1;
        end else begin
          d = longint'(n);
          rw = clamp32((aw <<< FRAC_BITS) / d, clp);
          rx = clamp32((ax <<< FRAC_BITS) / d, clp);
          ry = clamp32((ay <<< FRAC_BITS) / d, clp);
          rz = clamp32((az <<< FRAC_BITS) / d, clp);
        end
      end
    endcase
    res.w = rw[31:0];
    res.x = rx[31:0];
    res.y = ry[31:0];
    res.z = rz[31:0];
    res.zn = zn;
    res.clp = clp;
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t mismatch %s: got %h expected %h", $time, what, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin
    quat_result_t want;
    if (!rst && in_valid && !in_stall)
      expected_q.push_back(predict_quat(cmd_t'(cmd), a_w, a_x, a_y, a_z,
                                        b_w, b_x, b_y, b_z));
    if (!rst && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected transaction", 32'd0, 32'd0);
      end else begin
        want = expected_q.pop_front();
        matched++;
        if (r_w !== want.w) report_mismatch("r_w", r_w, want.w);
        if (r_x !== want.x) report_mismatch("r_x", r_x, want.x);
        if (r_y !== want.y) report_mismatch("r_y", r_y, want.y);
        if (r_z !== want.z) report_mismatch("r_z", r_z, want.z);
        if (zero_norm !== want.zn)
          report_mismatch("zero_norm", 32'(zero_norm), 32'(want.zn));
        if (clipped !== want.clp)
          report_mismatch("clipped", 32'(clipped), 32'(want.clp));
      end
    end
  end

endmodule

// ===== tb/quaternion_arith_unit_test.sv =====
`timescale 1ns / 1ps

module quaternion_arith_unit_test;
  import qau_pkg::*;

  localparam int RANDOM_ITEMS = 1250;
  localparam int CYCLE_LIMIT = 200000;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  logic [1:0]         cmd;
  logic signed [31:0] a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z;
  logic               out_valid;
  logic               out_stall;
  logic signed [31:0] r_w, r_x, r_y, r_z;
  logic               zero_norm;
  logic               clipped;
  int                 fail_count, pending, matched;
  int                 cycle_count;
  int                 sent;

  quaternion_arith_unit dut (.*);
  quaternion_arith_unit_checker chk (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("timeout after %0d cycles", cycle_count);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // Receiver stalls at random, with some stall-free stretches.
  initial begin
    int run;
    out_stall = 0;
    @(negedge rst);
    forever begin
      run = $urandom_range(1, 40);
      if ($urandom_range(0, 3) == 0) begin
        repeat (run) @(posedge clk) out_stall <= 0;
      end else begin
        repeat (run) @(posedge clk) out_stall <= ($urandom_range(0, 2) == 0);
      end
    end
  end

  function automatic logic [31:0] pick_value(input int kind);
    case (kind)
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0;
      3: return 32'h1000_0000;
      4: return 32'hF000_0000;
      5: return $urandom_range(0, 8) - 4;
      6, 7: return $signed($urandom_range(0, 32'h2000_0000)) - 32'sh1000_0000;
      default: return $urandom;
    endcase
  endfunction

  // Drive one transaction and hold it until accepted.
  task automatic send(input cmd_t op, input logic [31:0] w0, x0, y0, z0, w1, x1, y1, z1);
    in_valid <= 1;
    cmd <= op;
    a_w <= w0; a_x <= x0; a_y <= y0; a_z <= z0;
    b_w <= w1; b_x <= x1; b_y <= y1; b_z <= z1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
  endtask

  task automatic send_random(input cmd_t op);
    int mode;
    mode = $urandom_range(0, 9);
    send(op, pick_value(mode), pick_value($urandom_range(0, 9)),
         pick_value($urandom_range(0, 9)), pick_value($urandom_range(0, 9)),
         pick_value($urandom_range(0, 9)), pick_value($urandom_range(0, 9)),
         pick_value($urandom_range(0, 9)), pick_value($urandom_range(0, 9)));
  endtask

  initial begin
    int burst;
    logic [31:0] one_q, mn, mx;
    one_q = 32'h1000_0000;
    mn = 32'h8000_0000;
    mx = 32'h7FFF_FFFF;
    sent = 0;
    rst = 1;
    in_valid = 0;
    cmd = CMD_MUL;
    {a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z} = '0;
    repeat (10) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    send(CMD_MUL, one_q, 0, 0, 0, 32'h1234_5678, 32'h0123_4567, 32'hF000_0001, 5);
    send(CMD_MUL, mx, mx, mx, mx, mx, mx, mx, mx);
    send(CMD_MUL, mn, mn, mn, mn, mn, mn, mn, mn);
    send(CMD_MUL, mn, mx, mn, mx, mx, mn, mx, mn);
    send(CMD_MUL, 1, 1, -1, 32'h0800_0000, 1, -1, 1, 1);
    send(CMD_ROT, one_q, 0, 0, 0, 32'h5555_5555, one_q, 32'h0800_0000, mn);
    send(CMD_ROT, mx, mn, mx, mn, 0, mx, mn, mx);
    send(CMD_ROT, 32'h0B50_4F33, 0, 0, 32'h0B50_4F33, 0, one_q, 0, 0);
    send(CMD_ROT, mn, mn, mn, mn, mn, mn, mn, mn);
    send(CMD_CONJ, mn, mn, mx, 0, 0, 0, 0, 0);
    send(CMD_CONJ, mx, mx, mn, 32'hFFFF_FFFF, mx, mn, mx, mn);
    send(CMD_CONJ, 0, 0, 0, mn, 0, 0, 0, 0);
    send(CMD_NORM, 0, 0, 0, 0, mx, mx, mx, mx);
    send(CMD_NORM, mn, mn, mn, mn, 0, 0, 0, 0);
    send(CMD_NORM, mx, mx, mx, mx, 0, 0, 0, 0);
    send(CMD_NORM, 1, 0, 0, 0, 0, 0, 0, 0);
    send(CMD_NORM, 0, 0, 0, -1, 0, 0, 0, 0);
    send(CMD_NORM, one_q, one_q, one_q, one_q, 0, 0, 0, 0);
    send(CMD_NORM, mn, 0, 0, 0, 0, 0, 0, 0);

    while (sent < RANDOM_ITEMS + 19) begin
      burst = $urandom_range(1, 30);
      repeat (burst) send_random(cmd_t'($urandom_range(0, 3)));
      if ($urandom_range(0, 2) != 0) begin
        in_valid <= 0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
    in_valid <= 0;

    while (pending != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    $display("sent %0d transactions over all four opcodes, %0d results compared",
             sent, matched);
    if (fail_count == 0 && pending == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
